@@ hdl/bbps_pkg.sv @@
package bbps_pkg;

   // Number of valid patterns in the beep table
   localparam int unsigned PATTERN_COUNT = 9;

   // Request codes
   typedef enum logic [1:0] {
      REQ_SLOW_TICK = 2'd0,
      REQ_TONE_TICK = 2'd1,
      REQ_START     = 2'd2
   } req_code_type;

   // One beep table entry; on and period counts in slow ticks, repeat count in periods
   typedef struct packed {
      logic [7:0] on_ticks;
      logic [7:0] period_ticks;
      logic [7:0] repeat_count;
   } beep_entry_type;

   // One accepted request beat
   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] pattern_kind;
   } req_item_type;

   // One result beat
   typedef struct packed {
      logic pin_level;
      logic drive_enable;
      logic playing;
   } rsp_item_type;

   // Beep table; entries past the last pattern read as zero
   localparam beep_entry_type BEEP_ROM [16] = '{
      '{8'd8,  8'd16, 8'd1},
      '{8'd26, 8'd50, 8'd1},
      '{8'd8,  8'd25, 8'd5},
      '{8'd5,  8'd10, 8'd3},
      '{8'd5,  8'd10, 8'd3},
      '{8'd10, 8'd50, 8'd10},
      '{8'd10, 8'd50, 8'd10},
      '{8'd10, 8'd50, 8'd10},
      '{8'd5,  8'd25, 8'd10},
      '{8'd0,  8'd0,  8'd0},
      '{8'd0,  8'd0,  8'd0},
      '{8'd0,  8'd0,  8'd0},
      '{8'd0,  8'd0,  8'd0},
      '{8'd0,  8'd0,  8'd0},
      '{8'd0,  8'd0,  8'd0},
      '{8'd0,  8'd0,  8'd0}
   };

endpackage

@@ hdl/buzzer_beep_pattern_sequencer.sv @@
// Channel   Handshake               Payload
// req       req_valid / req_ready   req_type, req_pattern_kind
// rsp       rsp_valid / rsp_ready   rsp_pin_level, rsp_drive_enable, rsp_playing
// csr       csr_write_enable        csr_write_data (tone_half_rate)
//
// A request beat goes through the input and result registers; one beat per cycle is
// sustained while rsp is ready, set by the single state update between the two.
// Reset is synchronous and clears all pattern state; tone_half_rate resets to 1.
// A stalled rsp holds its beat; req stays ready while the input stage can drain.
module buzzer_beep_pattern_sequencer
   import bbps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [3:0] req_pattern_kind,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_pin_level,
   output logic       rsp_drive_enable,
   output logic       rsp_playing,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   logic         tone_half_rate_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type result;
   req_item_type req_item;
   req_item_type item;
   logic         item_valid;
   logic         advance;
   logic         fire;

   assign req_item.req_type     = req_type;
   assign req_item.pattern_kind = req_pattern_kind;

   // Beat moves to the result register when that register is free
   assign advance = !rsp_valid_ff || rsp_ready;
   assign fire    = item_valid && advance;

   bbps_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   bbps_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .tone_half_rate (tone_half_rate_ff),
      .fire           (fire),
      .item           (item),
      .result         (result)
   );

   // Config register
   always_ff @(posedge clock) begin
      if (reset) begin
         tone_half_rate_ff <= 1'b1;
      end else if (csr_write_enable) begin
         tone_half_rate_ff <= csr_write_data;
      end
   end

   // Result register
   assign rsp_valid_in = advance ? item_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pin_level    = rsp_item_ff.pin_level;
   assign rsp_drive_enable = rsp_item_ff.drive_enable;
   assign rsp_playing      = rsp_item_ff.playing;

endmodule

@@ hdl/bbps_in_stage.sv @@
module bbps_in_stage
   import bbps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // Stage takes a new beat when empty or when its beat moves on
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ hdl/bbps_engine.sv @@
module bbps_engine
   import bbps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         tone_half_rate,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [3:0] pending_kind_ff, pending_kind_in;
   logic [3:0] pattern_index_ff, pattern_index_in;
   logic [7:0] tick_count_ff, tick_count_in;
   logic [7:0] repeats_left_ff, repeats_left_in;
   logic       running_ff, running_in;
   logic       sounding_ff, sounding_in;
   logic       tone_phase_ff, tone_phase_in;
   logic       pin_state_ff, pin_state_in;
   logic       driver_on_ff, driver_on_in;

   // Next state for one request beat
   always_comb begin
      beep_entry_type entry;
      logic [7:0]     tick_next;
      logic           phase_next;

      pending_kind_in  = pending_kind_ff;
      pattern_index_in = pattern_index_ff;
      tick_count_in    = tick_count_ff;
      repeats_left_in  = repeats_left_ff;
      running_in       = running_ff;
      sounding_in      = sounding_ff;
      tone_phase_in    = tone_phase_ff;
      pin_state_in     = pin_state_ff;
      driver_on_in     = driver_on_ff;
      entry            = BEEP_ROM[pattern_index_ff];
      tick_next        = 8'd0;
      phase_next       = !tone_phase_ff;

      case (item.req_type)
         REQ_SLOW_TICK: begin
            // load a pending pattern first
            if (pending_kind_ff != 4'd0) begin
               pattern_index_in = pending_kind_ff - 4'd1;
               pending_kind_in  = 4'd0;
               repeats_left_in  = BEEP_ROM[pattern_index_in].repeat_count;
               tick_count_in    = 8'd0;
               sounding_in      = 1'b0;
               running_in       = 1'b1;
            end
            if (running_in) begin
               entry        = BEEP_ROM[pattern_index_in];
               tick_next    = tick_count_in + 8'd1;
               sounding_in  = (tick_next <= entry.on_ticks);
               driver_on_in = (tick_next <= entry.on_ticks);
               tick_count_in = tick_next;
               // end of period
               if (tick_next == entry.period_ticks) begin
                  repeats_left_in = repeats_left_in - 8'd1;
                  tick_count_in   = 8'd0;
                  if (repeats_left_in == 8'd0) begin
                     running_in   = 1'b0;
                     sounding_in  = 1'b0;
                     driver_on_in = 1'b0;
                  end
               end
            end
         end
         REQ_TONE_TICK: begin
            // pin toggles only while sounding
            if (sounding_ff) begin
               if (tone_half_rate) begin
                  tone_phase_in = phase_next;
                  if (phase_next) begin
                     pin_state_in = !pin_state_ff;
                  end
               end else begin
                  pin_state_in = !pin_state_ff;
               end
            end
         end
         REQ_START: begin
            if (item.pattern_kind >= 4'd1 &&
                item.pattern_kind <= 4'(PATTERN_COUNT)) begin
               pending_kind_in = item.pattern_kind;
            end
         end
         default: begin
            // reserved code: state holds
         end
      endcase
   end

   // State registers, updated once per processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_kind_ff  <= 4'd0;
         pattern_index_ff <= 4'd0;
         tick_count_ff    <= 8'd0;
         repeats_left_ff  <= 8'd0;
         running_ff       <= 1'b0;
         sounding_ff      <= 1'b0;
         tone_phase_ff    <= 1'b0;
         pin_state_ff     <= 1'b0;
         driver_on_ff     <= 1'b0;
      end else if (fire) begin
         pending_kind_ff  <= pending_kind_in;
         pattern_index_ff <= pattern_index_in;
         tick_count_ff    <= tick_count_in;
         repeats_left_ff  <= repeats_left_in;
         running_ff       <= running_in;
         sounding_ff      <= sounding_in;
         tone_phase_ff    <= tone_phase_in;
         pin_state_ff     <= pin_state_in;
         driver_on_ff     <= driver_on_in;
      end
   end

   // Result reflects the state after this beat
   assign result.pin_level    = pin_state_in;
   assign result.drive_enable = driver_on_in;
   assign result.playing      = running_in;

endmodule
